[rtl/hdf_pkg.sv]
// shared types, constants and codes for the hashed document-frequency block
`default_nettype none
package hdf_pkg;

	localparam int HASH_DIM_W      = 13;
	localparam int SCOPE_W         = 2;
	localparam int BUCKETS_DEFAULT = 4096;
	localparam int BUCKET_W_MAX    = 20;
	localparam int QUEUE_DEPTH     = 4;
	localparam int LOG_FRAC        = 40;
	localparam int LOG_W           = 46;

	localparam logic [31:0] COUNT_LIMIT = 32'hFFFF_FFFE;
	localparam logic [63:0] LN2_Q64     = 64'hB172_17F7_D1CF_79AC;

	localparam logic [1:0] OP_TOKEN   = 2'd0;
	localparam logic [1:0] OP_END_DOC = 2'd1;
	localparam logic [1:0] OP_QUERY   = 2'd2;

	localparam logic [1:0] SCOPE_CHAR = 2'd1;
	localparam logic [1:0] SCOPE_WORD = 2'd2;

	localparam logic REG_HASH_DIM = 1'b0;
	localparam logic REG_SCOPE    = 1'b1;

	typedef struct packed {
		logic [1:0]  operation;
		logic [63:0] token_hash;
		logic        char_ngram;
		logic [11:0] query_bucket;
	} hdf_in_t;

	typedef struct packed {
		logic [15:0] weight;
		logic [31:0] doc_frequency;
		logic        out_of_range;
	} hdf_out_t;

	typedef struct packed {
		logic [1:0]              op;
		logic                    oor;
		logic [BUCKET_W_MAX-1:0] bucket;
	} hdf_cmd_t;

	typedef struct packed {
		logic clearing;
	} hdf_status_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RD,
		ST_DEC,
		ST_NORM,
		ST_SQ_MUL,
		ST_SQ_ACC,
		ST_SQ_END,
		ST_LN_MUL,
		ST_LN_ACC,
		ST_FIN,
		ST_RES
	} hdf_back_state_t;

endpackage
`default_nettype wire

[rtl/hdf_queue.sv]
// small command queue between the front and back parts
`default_nettype none
module hdf_queue #(
	parameter int DEPTH = hdf_pkg::QUEUE_DEPTH
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            wr,
	input  hdf_pkg::hdf_cmd_t    wdata,
	output logic                 full,
	input  wire logic            rd,
	output hdf_pkg::hdf_cmd_t    rdata,
	output logic                 valid
);
	import hdf_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	hdf_cmd_t       slot_q [DEPTH];
	logic [PW-1:0]  wptr_q, rptr_q;
	logic [PW:0]    count_q;
	logic           do_wr, do_rd;

	assign full  = (count_q == (PW+1)'(DEPTH));
	assign valid = (count_q != '0);
	assign rdata = slot_q[rptr_q];
	assign do_wr = wr && !full;
	assign do_rd = rd && valid;

	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_wr) begin
				wptr_q <= (wptr_q == PW'(DEPTH-1)) ? '0 : wptr_q + 1'b1;
			end
			if (do_rd) begin
				rptr_q <= (rptr_q == PW'(DEPTH-1)) ? '0 : rptr_q + 1'b1;
			end
			count_q <= count_q + (PW+1)'(do_wr) - (PW+1)'(do_rd);
		end
	end

endmodule
`default_nettype wire

[rtl/hdf_front.sv]
// front part: accepts items, filters tokens, reduces the hash to a bucket
`default_nettype none
module hdf_front #(
	parameter int BUCKETS = hdf_pkg::BUCKETS_DEFAULT,
	parameter int DW      = $clog2(BUCKETS + 1)
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  hdf_pkg::hdf_in_t    item,
	input  wire logic           push,
	input  wire logic           stall,
	output logic                full,
	input  wire logic [DW-1:0]  dim,
	input  wire logic [1:0]     scope,
	output hdf_pkg::hdf_cmd_t   cmd,
	output logic                cmd_valid,
	input  wire logic           cmd_full
);
	import hdf_pkg::*;

	localparam int AW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
	localparam int EW = ((DW > 12) ? DW : 12) + 1;

	hdf_in_t        pend_q;
	logic           pend_valid_q, busy_q;
	logic [2:0]     cnt_q;
	logic [63:0]    h_q;
	logic [DW-1:0]  r_q, r_next;
	logic           take, keep;
	logic [EW-1:0]  q_ext, dim_ext;

	assign full = pend_valid_q || stall;
	assign take = push && !full;

	always_comb begin
		unique case (item.operation)
			OP_TOKEN:   keep = (scope == SCOPE_CHAR) ? item.char_ngram :
			                   (scope == SCOPE_WORD) ? !item.char_ngram : 1'b1;
			OP_END_DOC: keep = 1'b1;
			OP_QUERY:   keep = 1'b1;
			default:    keep = 1'b0;
		endcase
	end

	// eight restoring remainder steps per cycle
	always_comb begin
		logic [DW:0] r_t;
		r_t = {1'b0, r_q};
		for (int i = 0; i < 8; i++) begin
			r_t = {r_t[DW-1:0], h_q[63-i]};
			if (r_t >= {1'b0, dim}) begin
				r_t = r_t - {1'b0, dim};
			end
		end
		r_next = r_t[DW-1:0];
	end

	assign q_ext   = EW'(pend_q.query_bucket);
	assign dim_ext = EW'(dim);

	always_comb begin
		cmd        = '0;
		cmd.op     = pend_q.operation;
		cmd.oor    = (pend_q.operation == OP_QUERY) && (q_ext >= dim_ext);
		if (pend_q.operation == OP_QUERY) begin
			cmd.bucket[AW-1:0] = q_ext[AW-1:0];
		end else begin
			cmd.bucket[AW-1:0] = r_q[AW-1:0];
		end
		cmd_valid = pend_valid_q && !busy_q;
	end

	always_ff @(posedge clk) begin
		if (take) begin
			pend_q <= item;
			h_q    <= item.token_hash;
			r_q    <= '0;
		end else if (busy_q) begin
			h_q <= {h_q[55:0], 8'b0};
			r_q <= r_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
			busy_q       <= 1'b0;
			cnt_q        <= '0;
		end else if (take) begin
			pend_valid_q <= keep;
			busy_q       <= keep && (item.operation == OP_TOKEN);
			cnt_q        <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == 3'd7) begin
				busy_q <= 1'b0;
			end
		end else if (cmd_valid && !cmd_full) begin
			pend_valid_q <= 1'b0;
		end
	end

endmodule
`default_nettype wire

[rtl/hdf_back.sv]
// back part: bucket store, document counter and fixed-point idf unit
`default_nettype none
module hdf_back #(
	parameter int BUCKETS = hdf_pkg::BUCKETS_DEFAULT
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  hdf_pkg::hdf_cmd_t    cmd,
	input  wire logic            cmd_valid,
	output logic                 cmd_pop,
	output hdf_pkg::hdf_out_t    result,
	output logic                 empty,
	input  wire logic            pop,
	output hdf_pkg::hdf_status_t status
);
	import hdf_pkg::*;

	localparam int AW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;

	hdf_back_state_t state_q, state_d;

	logic [63:0]    mem [BUCKETS];
	logic [63:0]    rdata_q, mem_wdata;
	logic           mem_we;
	logic [AW-1:0]  mem_waddr, clr_q;

	hdf_cmd_t       cmd_q;
	logic [31:0]    docs_q, marker, cnt_rd, df_q;
	logic [63:0]    y_q, mul_q, op_a, op_b, ysq, ynew;
	logic [5:0]     e_q, it_q;
	logic [39:0]    frac_q, frac_new;
	logic [1:0]     k_q;
	logic [127:0]   acc_q, acc_add;
	logic [LOG_W-1:0] a_q, diff_q, log_new;
	logic           which_q, oor_q, out_valid_q, log_done;
	logic [15:0]    w_q, w_fin;
	logic [73:0]    w_wide;
	logic [33:0]    x_a, x_b;
	hdf_out_t       out_q;

	assign marker   = docs_q + 32'd1;
	assign cnt_rd   = rdata_q[63:32];
	assign ysq      = acc_q[125:62];
	assign ynew     = ysq[63] ? {1'b0, ysq[63:1]} : ysq;
	assign frac_new = {frac_q[38:0], ysq[63]};
	assign log_new  = {e_q, frac_new};
	assign log_done = (it_q == 6'(LOG_FRAC - 1));
	assign x_a      = {1'b0, docs_q, 1'b0} + 34'd2;
	assign x_b      = {1'b0, df_q, 1'b1};

	assign w_wide = {acc_q[127:64], 10'b0} + (74'd1 << (LOG_FRAC - 1));
	assign w_fin  = (|w_wide[73:56]) ? 16'hFFFF : w_wide[55:40];

	assign status.clearing = (state_q == ST_CLEAR);
	assign cmd_pop = (state_q == ST_IDLE) && cmd_valid;
	assign result  = out_q;
	assign empty   = !out_valid_q;

	// partial product selection for squaring and the ln 2 scaling
	always_comb begin
		op_a = '0;
		op_b = '0;
		if (state_q == ST_LN_MUL) begin
			op_a = {32'b0, (k_q[1] ? {14'b0, diff_q[45:32]} : diff_q[31:0])};
			op_b = {32'b0, (k_q[0] ? LN2_Q64[63:32] : LN2_Q64[31:0])};
		end else begin
			op_a = {32'b0, (k_q == 2'd2) ? y_q[63:32] : y_q[31:0]};
			op_b = {32'b0, (k_q == 2'd0) ? y_q[31:0] : y_q[63:32]};
		end
	end

	always_comb begin
		if (state_q == ST_LN_ACC) begin
			unique case (k_q)
				2'd0:    acc_add = {64'b0, mul_q};
				2'd3:    acc_add = {mul_q, 64'b0};
				default: acc_add = {32'b0, mul_q, 32'b0};
			endcase
		end else begin
			unique case (k_q)
				2'd0:    acc_add = {64'b0, mul_q};
				2'd1:    acc_add = {31'b0, mul_q, 33'b0};
				default: acc_add = {mul_q, 64'b0};
			endcase
		end
	end

	always_comb begin
		state_d   = state_q;
		mem_we    = 1'b0;
		mem_waddr = cmd_q.bucket[AW-1:0];
		mem_wdata = {(cnt_rd < COUNT_LIMIT) ? cnt_rd + 32'd1 : cnt_rd, marker};
		unique case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = '0;
				if (clr_q == AW'(BUCKETS - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (cmd_valid) begin
					if (cmd.op == OP_TOKEN) begin
						state_d = ST_RD;
					end else if (cmd.op == OP_QUERY) begin
						state_d = cmd.oor ? ST_RES : ST_RD;
					end
				end
			end
			ST_RD: state_d = ST_DEC;
			ST_DEC: begin
				if (cmd_q.op == OP_TOKEN) begin
					mem_we  = (rdata_q[31:0] != marker);
					state_d = ST_IDLE;
				end else begin
					state_d = ST_NORM;
				end
			end
			ST_NORM:   state_d = y_q[62] ? ST_SQ_MUL : ST_NORM;
			ST_SQ_MUL: state_d = ST_SQ_ACC;
			ST_SQ_ACC: state_d = (k_q == 2'd2) ? ST_SQ_END : ST_SQ_MUL;
			ST_SQ_END: begin
				if (!log_done) begin
					state_d = ST_SQ_MUL;
				end else if (!which_q) begin
					state_d = ST_NORM;
				end else begin
					state_d = (a_q <= log_new) ? ST_RES : ST_LN_MUL;
				end
			end
			ST_LN_MUL: state_d = ST_LN_ACC;
			ST_LN_ACC: state_d = (k_q == 2'd3) ? ST_FIN : ST_LN_MUL;
			ST_FIN:    state_d = ST_RES;
			ST_RES:    state_d = (!out_valid_q || pop) ? ST_IDLE : ST_RES;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rdata_q <= mem[cmd_q.bucket[AW-1:0]];
	end

	// datapath registers
	always_ff @(posedge clk) begin
		mul_q <= op_a * op_b;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					cmd_q <= cmd;
					oor_q <= cmd.oor;
					w_q   <= '0;
					df_q  <= '0;
				end
			end
			ST_DEC: begin
				df_q    <= cnt_rd;
				y_q     <= {1'b0, x_a, 29'b0};
				e_q     <= 6'd33;
				which_q <= 1'b0;
				it_q    <= '0;
				frac_q  <= '0;
				k_q     <= '0;
				acc_q   <= '0;
			end
			ST_NORM: begin
				if (!y_q[62]) begin
					y_q <= {y_q[62:0], 1'b0};
					e_q <= e_q - 6'd1;
				end
			end
			ST_SQ_ACC, ST_LN_ACC: begin
				acc_q <= acc_q + acc_add;
				k_q   <= k_q + 2'd1;
			end
			ST_SQ_END: begin
				acc_q <= '0;
				k_q   <= '0;
				if (!log_done) begin
					y_q    <= ynew;
					frac_q <= frac_new;
					it_q   <= it_q + 6'd1;
				end else if (!which_q) begin
					a_q     <= log_new;
					which_q <= 1'b1;
					y_q     <= {1'b0, x_b, 29'b0};
					e_q     <= 6'd33;
					it_q    <= '0;
					frac_q  <= '0;
				end else begin
					diff_q <= a_q - log_new;
				end
			end
			ST_FIN: w_q <= w_fin;
			default: begin
			end
		endcase
		if (state_q == ST_RES && (!out_valid_q || pop)) begin
			out_q.weight        <= w_q;
			out_q.doc_frequency <= df_q;
			out_q.out_of_range  <= oor_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			docs_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (cmd_pop && cmd.op == OP_END_DOC && docs_q < COUNT_LIMIT) begin
				docs_q <= docs_q + 32'd1;
			end
			if (state_q == ST_RES && (!out_valid_q || pop)) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

[rtl/hashed_document_frequency_idf.sv]
// top level: configuration registers, front part, command queue and back part
// a token passes the hash remainder in the front, then a read-modify-write in the back
// an in-range query runs two fixed-point log2 evaluations of 40 squaring steps each on one
//   shared 32x32 multiplier, plus the ln 2 scaling when the first log exceeds the second
// a new item waits until the last command is queued; tokens paced by remainder, queries by log unit
// reset: the bucket store is swept clear, one entry a cycle, with full held high
`default_nettype none
module hashed_document_frequency_idf #(
	parameter int BUCKETS = hdf_pkg::BUCKETS_DEFAULT
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  hdf_pkg::hdf_in_t item,
	input  wire logic        push,
	output logic             full,
	output hdf_pkg::hdf_out_t result,
	output logic             empty,
	input  wire logic        pop,
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [12:0] cfg_data
);
	import hdf_pkg::*;

	// bucket modulus width and a compare width that holds both it and the register
	localparam int DW = $clog2(BUCKETS + 1);
	localparam int HW = (HASH_DIM_W > DW) ? HASH_DIM_W : DW;

	logic [HASH_DIM_W-1:0] hash_dim_q;
	logic [SCOPE_W-1:0]    scope_q;
	logic [HW-1:0]         hd_ext, eff_ext;
	logic [DW-1:0]         eff_dim;

	hdf_cmd_t    f_cmd, q_cmd;
	logic        f_cmd_valid, q_full, q_valid, b_pop;
	hdf_status_t b_status;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_dim_q <= HASH_DIM_W'(4096);
			scope_q    <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_HASH_DIM: hash_dim_q <= cfg_data;
				REG_SCOPE:    scope_q    <= cfg_data[SCOPE_W-1:0];
			endcase
		end
	end

	// zero acts as one bucket, anything past the store acts as the store size
	assign hd_ext = HW'(hash_dim_q);
	always_comb begin
		if (hd_ext == '0) begin
			eff_ext = HW'(1);
		end else if (hd_ext > HW'(BUCKETS)) begin
			eff_ext = HW'(BUCKETS);
		end else begin
			eff_ext = hd_ext;
		end
	end
	assign eff_dim = eff_ext[DW-1:0];

	// front: takes a transaction, filters and reduces it to a command
	hdf_front #(.BUCKETS(BUCKETS), .DW(DW)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.push      (push),
		.stall     (b_status.clearing),
		.full      (full),
		.dim       (eff_dim),
		.scope     (scope_q),
		.cmd       (f_cmd),
		.cmd_valid (f_cmd_valid),
		.cmd_full  (q_full)
	);

	// decoupling queue so the front keeps hashing while the back works a query
	hdf_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (f_cmd_valid),
		.wdata  (f_cmd),
		.full   (q_full),
		.rd     (b_pop),
		.rdata  (q_cmd),
		.valid  (q_valid)
	);

	// back: bucket store, document count, idf unit and result register
	hdf_back #(.BUCKETS(BUCKETS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (q_cmd),
		.cmd_valid (q_valid),
		.cmd_pop   (b_pop),
		.result    (result),
		.empty     (empty),
		.pop       (pop),
		.status    (b_status)
	);

endmodule
`default_nettype wire

[tb/tb.sv]
// self-checking testbench for the hashed document-frequency block
`timescale 1ns / 100ps
`default_nettype none
module tb;
	import hdf_pkg::*;

	localparam int          NBUCKETS    = 4096;
	localparam int          CYCLE_LIMIT = 3000000;
	localparam int          SETTLE      = 40;   // token read-modify-write finishes well inside this
	localparam int          TAIL        = 700;  // longer than one query
	localparam logic [1:0]  OP_IGNORED  = 2'd3;
	localparam logic [1:0]  SCOPE_ALL   = 2'd0;

	logic        clk;
	logic        arst_n;
	hdf_in_t     item;
	logic        push;
	logic        full;
	hdf_out_t    result;
	logic        empty;
	logic        pop;
	logic        cfg_we;
	logic        cfg_index;
	logic [12:0] cfg_data;

	hashed_document_frequency_idf DUT (
		.clk(clk), .arst_n(arst_n), .item(item), .push(push), .full(full),
		.result(result), .empty(empty), .pop(pop),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// predictor state: counts, last document marker per bucket, documents seen
	logic [31:0] df_store[NBUCKETS];
	logic [31:0] last_doc_store[NBUCKETS];
	logic [31:0] docs_seen;
	logic [12:0] dim_reg;
	logic [1:0]  scope_reg;

	// newest expectation at the front, oldest at the back
	hdf_out_t    pending_weights[$];
	int          fail_count = 0;
	int          cycles = 0;
	bit          quiet = 0;      // no idling on either side while set
	logic [63:0] hash_pool[8];

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb failed");
			$finish;
		end
	end

	function automatic int active_dim();
		if (dim_reg == 0)
			return 1;
		if (dim_reg > NBUCKETS)
			return NBUCKETS;
		return int'(dim_reg);
	endfunction

	// log2 with 40 fractional bits by repeated squaring of a Q2.62 mantissa
	function automatic logic [63:0] log2_q40(logic [63:0] x);
		int          e;
		logic [63:0] y;
		logic [63:0] frac;
		logic [127:0] sq;
		e = 0;
		frac = 0;
		while (e < 63 && (x >> (e + 1)) != 0)
			e++;
		y = x << (62 - e);
		for (int i = 0; i < 40; i++) begin
			sq = y * y;
			y = sq[125:62];
			frac = frac << 1;
			if (y[63]) begin
				frac[0] = 1'b1;
				y = y >> 1;
			end
		end
		return (64'(e) << 40) | frac;
	endfunction

	function automatic logic [15:0] idf_of(logic [31:0] n, logic [31:0] df);
		logic [63:0]  a;
		logic [63:0]  b;
		logic [127:0] prod;
		logic [63:0]  w;
		a = log2_q40(2 * 64'(n) + 2);
		b = log2_q40(2 * 64'(df) + 1);
		if (a <= b)
			return 16'd0;
		prod = (a - b) * LN2_Q64;
		w = (prod[127:64] * 1024 + (64'd1 << 39)) >> 40;
		return (w > 65535) ? 16'hFFFF : w[15:0];
	endfunction

	// advance the predictor by one accepted transaction
	task automatic predict(hdf_in_t it);
		int       dim;
		int       b;
		hdf_out_t r;
		dim = active_dim();
		case (it.operation)
			OP_TOKEN: begin
				if (!((scope_reg == SCOPE_CHAR && !it.char_ngram) ||
				      (scope_reg == SCOPE_WORD && it.char_ngram))) begin
					b = int'(it.token_hash % 64'(dim));
					if (last_doc_store[b] != docs_seen + 1) begin
						last_doc_store[b] = docs_seen + 1;
						if (df_store[b] < COUNT_LIMIT)
							df_store[b]++;
					end
				end
			end
			OP_END_DOC: begin
				if (docs_seen < COUNT_LIMIT)
					docs_seen++;
			end
			OP_QUERY: begin
				if (it.query_bucket >= dim) begin
					r.weight = 0;
					r.doc_frequency = 0;
					r.out_of_range = 1'b1;
				end else begin
					r.doc_frequency = df_store[it.query_bucket];
					r.weight = idf_of(docs_seen, r.doc_frequency);
					r.out_of_range = 1'b0;
				end
				pending_weights.push_front(r);
			end
			default: ;  // ignored operation
		endcase
	endtask

	// send one transaction, sometimes after a random gap (never while quiet); push stays high afterwards
	task automatic send_item(hdf_in_t it);
		if (!quiet && $urandom_range(99) < 17) begin
			push = 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		item = it;
		push = 1'b1;
		forever begin
			@(posedge clk);
			if (!full)
				break;
		end
		predict(it);
		@(negedge clk);
	endtask

	function automatic hdf_in_t make_item(logic [1:0] op, logic [63:0] h, logic ch,
	                                      logic [11:0] q);
		hdf_in_t it;
		it.operation = op;
		it.token_hash = h;
		it.char_ngram = ch;
		it.query_bucket = q;
		return it;
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	// wait until the block is idle, then write one register
	task automatic write_reg(logic idx, logic [12:0] val);
		push = 1'b0;
		while (pending_weights.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_we = 1'b0;
		if (idx == REG_HASH_DIM)
			dim_reg = val;
		else
			scope_reg = val[1:0];
	endtask

	// result side: random stalls, compare against the oldest expectation
	always @(negedge clk)
		pop <= quiet ? 1'b1 : ($urandom_range(99) >= 17);

	always @(posedge clk) begin
		hdf_out_t want;
		if (arst_n && !empty && pop) begin
			if (pending_weights.size() == 0) begin
				$error("result transaction with no expectation waiting");
				fail_count++;
			end else begin
				want = pending_weights.pop_back();
				if (result.weight !== want.weight) begin
					$error("weight: expected %0d, actual %0d", want.weight, result.weight);
					fail_count++;
				end
				if (result.doc_frequency !== want.doc_frequency) begin
					$error("doc_frequency: expected %0d, actual %0d",
					       want.doc_frequency, result.doc_frequency);
					fail_count++;
				end
				if (result.out_of_range !== want.out_of_range) begin
					$error("out_of_range: expected %0d, actual %0d",
					       want.out_of_range, result.out_of_range);
					fail_count++;
				end
			end
		end
	end

	// field extremes, every operation, repeated hits in one document
	task automatic test_directed();
		send_item(make_item(OP_QUERY, 0, 0, 12'd0));          // empty store, no documents
		send_item(make_item(OP_QUERY, 0, 0, 12'hFFF));
		send_item(make_item(OP_TOKEN, 64'd0, 1'b0, 0));
		send_item(make_item(OP_TOKEN, 64'd0, 1'b1, 0));        // same bucket, same document
		send_item(make_item(OP_TOKEN, '1, 1'b1, 12'hFFF));     // all-ones hash
		send_item(make_item(OP_IGNORED, '1, 1'b1, 12'hFFF));   // ignored operation
		send_item(make_item(OP_END_DOC, 0, 0, 0));
		send_item(make_item(OP_QUERY, 0, 0, 12'd0));
		send_item(make_item(OP_TOKEN, 64'd4096, 1'b0, 0));     // wraps to bucket zero
		send_item(make_item(OP_END_DOC, 0, 0, 0));
		send_item(make_item(OP_END_DOC, 0, 0, 0));
		send_item(make_item(OP_QUERY, 0, 0, 12'd0));
		send_item(make_item(OP_QUERY, 0, 0, 12'hFFF));
		send_item(make_item(OP_QUERY, 0, 0, 12'd1));
	endtask

	// modulus extremes and scope filter values, counts kept across changes
	task automatic test_register_extremes();
		write_reg(REG_HASH_DIM, 13'd1);
		send_item(make_item(OP_TOKEN, rand64(), 1'b1, 0));
		send_item(make_item(OP_QUERY, 0, 0, 12'd0));
		send_item(make_item(OP_QUERY, 0, 0, 12'd1));           // out of range
		write_reg(REG_HASH_DIM, 13'd0);                        // treated as one
		send_item(make_item(OP_QUERY, 0, 0, 12'd1));
		write_reg(REG_HASH_DIM, 13'h1FFF);                     // clipped to the store size
		send_item(make_item(OP_QUERY, 0, 0, 12'hFFF));
		for (int s = 0; s < 4; s++) begin
			write_reg(REG_SCOPE, 13'(s));
			send_item(make_item(OP_TOKEN, 64'd77, 1'b1, 0));
			send_item(make_item(OP_TOKEN, 64'd78, 1'b0, 0));
			send_item(make_item(OP_END_DOC, 0, 0, 0));
			send_item(make_item(OP_QUERY, 0, 0, 12'd77));
			send_item(make_item(OP_QUERY, 0, 0, 12'd78));
		end
	endtask

	// documents of tokens drawn from a small pool, queries aimed at the hit buckets
	task automatic test_random_documents();
		logic [12:0] dims[7] = '{13'd4096, 13'd1, 13'd7, 13'd4095, 13'd100, 13'h1FFF, 13'd0};
		logic [63:0] h;
		logic [11:0] q;
		int          dim;
		int          n;
		int          pick;
		for (int ph = 0; ph < 7; ph++) begin
			write_reg(REG_HASH_DIM, dims[ph]);
			write_reg(REG_SCOPE, 13'($urandom_range(3)));
			quiet = (ph == 3);
			dim = active_dim();
			foreach (hash_pool[i])
				hash_pool[i] = rand64();
			n = 0;
			while (n < 180) begin
				pick = int'($urandom_range(99));
				if (pick <= 64) begin
					h = ($urandom_range(9) < 8) ? hash_pool[$urandom_range(7)] : rand64();
					send_item(make_item(OP_TOKEN, h, $urandom_range(1), 12'($urandom())));
				end else if (pick <= 77) begin
					send_item(make_item(OP_END_DOC, rand64(), $urandom_range(1),
					                    12'($urandom())));
				end else if (pick <= 95) begin
					if ($urandom_range(9) < 7)
						q = 12'(hash_pool[$urandom_range(7)] % 64'(dim));
					else
						q = 12'($urandom());
					send_item(make_item(OP_QUERY, rand64(), $urandom_range(1), q));
				end else begin
					send_item(make_item(OP_IGNORED, rand64(), $urandom_range(1),
					                    12'($urandom())));
				end
				n++;
			end
		end
		quiet = 0;
	endtask

	// sender holds off until every outstanding result has come back
	task automatic test_drain_pause();
		send_item(make_item(OP_QUERY, 0, 0, 12'd0));
		send_item(make_item(OP_QUERY, 0, 0, 12'd5));
		push = 1'b0;
		while (pending_weights.size() != 0)
			@(negedge clk);
		send_item(make_item(OP_QUERY, 0, 0, 12'd0));
	endtask

	initial begin
		arst_n = 1'b0;
		push = 1'b0;
		item = '0;
		cfg_we = 1'b0;
		cfg_index = REG_HASH_DIM;
		cfg_data = '0;
		foreach (df_store[i]) begin
			df_store[i] = 0;
			last_doc_store[i] = 0;
		end
		docs_seen = 0;
		dim_reg = 13'd4096;
		scope_reg = SCOPE_ALL;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_register_extremes();
		test_random_documents();
		test_drain_pause();

		push = 1'b0;
		while (pending_weights.size() != 0)
			@(negedge clk);
		repeat (TAIL) @(negedge clk);
		if (fail_count == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

endmodule
`default_nettype wire

[filelist.f]
rtl/hdf_pkg.sv
rtl/hdf_queue.sv
rtl/hdf_front.sv
rtl/hdf_back.sv
rtl/hashed_document_frequency_idf.sv
tb/tb.sv
